// ----- hdl/lps_pkg.sv -----
// Shared types and constants for the lookahead point search block.
// Used by lookahead_point_search and lps_checker; no dependencies.
package lps_pkg;

   // Field widths on the stream ports
   localparam int COORD_W  = 20;
   localparam int DATA_W   = 2 * COORD_W;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int RADIUS_W = 16;

   // Transaction kinds carried in req_tuser
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   // Result kinds carried in rsp_tuser
   localparam logic [STATUS_W-1:0] STATUS_SEGMENT = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_END     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT   = 2'd2;

   // Query sequencer states
   typedef enum logic [4:0] {
      S_IDLE,
      S_END_RD,
      S_END_CAP,
      S_END_CHK,
      S_SEG_RD0,
      S_SEG_CAP0,
      S_SEG_RD1,
      S_SEG_CAP1,
      S_SEG_MUL,
      S_DISC,
      S_SQRT_INIT,
      S_SQRT,
      S_ROOT,
      S_DIV,
      S_CHK,
      S_DIST,
      S_ADV,
      S_INT_RD0,
      S_INT_CAP0,
      S_INT_RD1,
      S_INT_CAP1,
      S_INTERP,
      S_RESP
   } state_type;

endpackage

// ----- hdl/lps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lps_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/lookahead_point_search.sv -----
// Lookahead point search: point store, circle-segment intersection and target interpolation.
// Clear and append finish on acceptance; a short-path query skips the search, and a query
// with the path end in reach returns the end point. Otherwise segments are walked from the
// search index (42-step square root, 17-step divider, one 23x23 multiplier), then the target
// is interpolated. One transaction at a time; a held result stalls the end.
// Synchronous active-high reset clears point count, search index, fraction, radius, result valid.
module lookahead_point_search #(
   parameter int MAX_POINTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [19:0] coord_x, [39:20] coord_y
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [19:0] target_x, [39:20] target_y
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int CW1    = CNT_W + 1;
   localparam int CW     = lps_pkg::COORD_W;
   localparam int DIFF_W = CW + 1;
   localparam int MOP_W  = 23;
   localparam int PROD_W = 2 * MOP_W;
   localparam int SQ_W   = 42;
   localparam int WIDE_W = 44;
   localparam int HALF_W = WIDE_W / 2;
   localparam int DISC_W = 86;
   localparam int RAD_W  = 84;
   localparam int ROOT_W = RAD_W / 2;
   localparam int SREM_W = 46;
   localparam int N_W    = 46;
   localparam int DREM_W = SQ_W + 1;
   localparam int FRAC_W = 17;
   localparam int STEP_W = 6;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 46'sd32768;

   function automatic logic signed [DIFF_W-1:0] diff(input logic signed [CW-1:0] p,
                                                     input logic signed [CW-1:0] q);
      return DIFF_W'(p) - DIFF_W'(q);
   endfunction

   function automatic logic [HALF_W-1:0] half_sel(input logic [WIDE_W-1:0] v, input logic hi);
      return hi ? v[WIDE_W-1:HALF_W] : v[HALF_W-1:0];
   endfunction

   // Registers
   lps_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [lps_pkg::RADIUS_W-1:0] radius_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         sidx_ff, sidx_in, i_ff, i_in, found_ff, found_in;
   logic [FRAC_W-1:0]        sfrac_ff, sfrac_in, quo_ff, quo_in;
   logic signed [CW-1:0]     px_ff, px_in, py_ff, py_in, sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CW-1:0]     ex_ff, ex_in, ey_ff, ey_in, fnd_x_ff, fnd_x_in, fnd_y_ff, fnd_y_in;
   logic signed [CW-1:0]     tx_ff, tx_in, ty_ff, ty_in;
   logic [lps_pkg::STATUS_W-1:0] status_ff, status_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SQ_W-1:0]          a_ff, a_in;
   logic signed [WIDE_W-1:0] h_ff, h_in, c_ff, c_in;
   logic signed [DISC_W-1:0] acc_ff, acc_in;
   logic [RAD_W-1:0]         rad_ff, rad_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [SREM_W-1:0]        srem_ff, srem_in;
   logic [DREM_W-1:0]        drem_ff, drem_in;
   logic                     isect_ff, isect_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [lps_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [lps_pkg::STATUS_W-1:0] rsp_user_ff, rsp_user_in;

   // Control and memory signals
   logic                     req_accept, resp_load;
   logic [lps_pkg::OP_W-1:0] req_op;
   logic                     mem_wr_en;
   logic [IDX_W-1:0]         mem_rd_addr;
   logic [lps_pkg::DATA_W-1:0] mem_rd_data;
   logic signed [CW-1:0]     rd_x, rd_y;
   logic signed [MOP_W-1:0]  mul_a, mul_b;

   // Datapath helpers
   logic signed [DIFF_W-1:0] dx, dy, fx, fy, gx, gy, qx, qy;
   logic [WIDE_W-1:0]        abs_h, abs_c, big_x, big_y;
   logic                     c_neg;
   logic [STEP_W-1:0]        step_m1;
   logic signed [DISC_W-1:0] acc_term;
   logic [SREM_W-1:0]        rem_sh, trial;
   logic                     sq_ge;
   logic signed [N_W-1:0]    rootv, hv, av, n1, n2;
   logic                     ok1, ok2;
   logic [DREM_W-1:0]        dcand;
   logic                     d_ge;
   logic                     upd, brk;
   logic [IDX_W-1:0]         found_new, int_idx;
   logic signed [PROD_W-1:0] rounded;
   logic                     more_seg, start_ok, end_near, dist_far;

   assign req_op = req_tuser;
   assign req_accept = req_tvalid && req_tready;
   assign rd_x = $signed(mem_rd_data[CW-1:0]);
   assign rd_y = $signed(mem_rd_data[2*CW-1:CW]);

   // Point store: x in the low half, y in the high half
   lps_ram #(.WIDTH(lps_pkg::DATA_W), .DEPTH(MAX_POINTS)) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Differences and derived terms
   assign dx = diff(ex_ff, sx_ff);
   assign dy = diff(ey_ff, sy_ff);
   assign fx = diff(sx_ff, px_ff);
   assign fy = diff(sy_ff, py_ff);
   assign gx = diff(ex_ff, px_ff);
   assign gy = diff(ey_ff, py_ff);
   assign qx = diff(sx_ff, fnd_x_ff);
   assign qy = diff(sy_ff, fnd_y_ff);
   assign c_neg = c_ff[WIDE_W-1];
   assign abs_h = h_ff[WIDE_W-1] ? WIDE_W'(-h_ff) : WIDE_W'(h_ff);
   assign abs_c = c_neg ? WIDE_W'(-c_ff) : WIDE_W'(c_ff);
   assign big_x = step_ff[2] ? {{(WIDE_W-SQ_W){1'b0}}, a_ff} : abs_h;
   assign big_y = step_ff[2] ? abs_c : abs_h;
   assign step_m1 = step_ff - STEP_W'(1);

   // Shift the registered partial product into place
   always_comb begin
      acc_term = DISC_W'(prod_ff);
      if (step_m1[1:0] == 2'd3) begin
         acc_term = acc_term <<< (2 * HALF_W);
      end else if (step_m1[1:0] != 2'd0) begin
         acc_term = acc_term <<< HALF_W;
      end
   end

   // Square root digit step
   assign rem_sh = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign sq_ge  = rem_sh >= trial;

   // Root candidates: far root first
   assign rootv = $signed({{(N_W-ROOT_W){1'b0}}, root_ff});
   assign hv    = N_W'(h_ff);
   assign av    = $signed({{(N_W-SQ_W){1'b0}}, a_ff});
   assign n1    = rootv - hv;
   assign n2    = -hv - rootv;
   assign ok1   = !n1[N_W-1] && (n1 <= av);
   assign ok2   = !n2[N_W-1] && (n2 <= av);

   // Divider step
   assign dcand = (step_ff == '0) ? drem_ff : {drem_ff[DREM_W-2:0], 1'b0};
   assign d_ge  = dcand >= {1'b0, a_ff};

   // Progress rule and exits
   assign upd = isect_ff && ((i_ff > sidx_ff) || (quo_ff > sfrac_ff));
   assign brk = upd && (found_ff != '0);
   assign found_new = (upd && (found_ff == '0)) ? i_ff : found_ff;
   assign more_seg = (CW1'(i_ff) + CW1'(2)) < CW1'(count_ff);
   assign start_ok = (CW1'(sidx_ff) + CW1'(1)) < CW1'(count_ff);
   assign int_idx  = start_ok ? sidx_ff : IDX_W'(count_ff - CNT_W'(2));
   assign end_near = {{(PROD_W-SQ_W){1'b0}}, a_ff} <= $unsigned(prod_ff);
   assign dist_far = a_ff >= {prod_ff[SQ_W-3:0], 2'b00};
   assign rounded  = prod_ff + ROUND_HALF;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lps_pkg::S_IDLE: begin
            if (req_accept && (req_op == lps_pkg::OP_QUERY)) begin
               state_in = (count_ff < CNT_W'(2)) ? lps_pkg::S_RESP : lps_pkg::S_END_RD;
            end
         end
         lps_pkg::S_END_RD:    state_in = lps_pkg::S_END_CAP;
         lps_pkg::S_END_CAP:   state_in = lps_pkg::S_END_CHK;
         lps_pkg::S_END_CHK: begin
            if (step_ff == STEP_W'(3)) begin
               state_in = end_near ? lps_pkg::S_RESP : lps_pkg::S_SEG_RD0;
            end
         end
         lps_pkg::S_SEG_RD0:   state_in = start_ok ? lps_pkg::S_SEG_CAP0 : lps_pkg::S_INT_RD0;
         lps_pkg::S_SEG_CAP0:  state_in = lps_pkg::S_SEG_RD1;
         lps_pkg::S_SEG_RD1:   state_in = lps_pkg::S_SEG_CAP1;
         lps_pkg::S_SEG_CAP1:  state_in = lps_pkg::S_SEG_MUL;
         lps_pkg::S_SEG_MUL: begin
            if (step_ff == STEP_W'(7)) begin
               state_in = lps_pkg::S_DISC;
            end
         end
         lps_pkg::S_DISC: begin
            if ((step_ff == '0) && (a_ff == '0)) begin
               state_in = lps_pkg::S_CHK;
            end else if (step_ff == STEP_W'(8)) begin
               state_in = lps_pkg::S_SQRT_INIT;
            end
         end
         lps_pkg::S_SQRT_INIT: state_in = acc_ff[DISC_W-1] ? lps_pkg::S_CHK : lps_pkg::S_SQRT;
         lps_pkg::S_SQRT: begin
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = lps_pkg::S_ROOT;
            end
         end
         lps_pkg::S_ROOT:      state_in = (ok1 || ok2) ? lps_pkg::S_DIV : lps_pkg::S_CHK;
         lps_pkg::S_DIV: begin
            if (step_ff == STEP_W'(FRAC_W - 1)) begin
               state_in = lps_pkg::S_CHK;
            end
         end
         lps_pkg::S_CHK: begin
            if (brk) begin
               state_in = lps_pkg::S_INT_RD0;
            end else if (found_new != '0) begin
               state_in = lps_pkg::S_DIST;
            end else begin
               state_in = lps_pkg::S_ADV;
            end
         end
         lps_pkg::S_DIST: begin
            if (step_ff == STEP_W'(3)) begin
               state_in = dist_far ? lps_pkg::S_INT_RD0 : lps_pkg::S_ADV;
            end
         end
         lps_pkg::S_ADV:       state_in = more_seg ? lps_pkg::S_SEG_RD1 : lps_pkg::S_INT_RD0;
         lps_pkg::S_INT_RD0:   state_in = lps_pkg::S_INT_CAP0;
         lps_pkg::S_INT_CAP0:  state_in = lps_pkg::S_INT_RD1;
         lps_pkg::S_INT_RD1:   state_in = lps_pkg::S_INT_CAP1;
         lps_pkg::S_INT_CAP1:  state_in = lps_pkg::S_INTERP;
         lps_pkg::S_INTERP: begin
            if (step_ff == STEP_W'(2)) begin
               state_in = lps_pkg::S_RESP;
            end
         end
         lps_pkg::S_RESP: begin
            if (resp_load) begin
               state_in = lps_pkg::S_IDLE;
            end
         end
         default:     state_in = lps_pkg::S_IDLE;
      endcase
   end

   // Control outputs: handshake, memory port and multiplier operands
   always_comb begin
      req_tready  = (state_ff == lps_pkg::S_IDLE);
      resp_load   = (state_ff == lps_pkg::S_RESP) && (!rsp_valid_ff || rsp_tready);
      mem_wr_en   = req_accept && (req_op == lps_pkg::OP_APPEND)
                    && (count_ff < CNT_W'(MAX_POINTS));
      mem_rd_addr = i_ff;
      mul_a       = '0;
      mul_b       = '0;
      case (state_ff)
         lps_pkg::S_END_RD:  mem_rd_addr = IDX_W'(count_ff - CNT_W'(1));
         lps_pkg::S_SEG_RD0: mem_rd_addr = sidx_ff;
         lps_pkg::S_SEG_RD1, lps_pkg::S_INT_RD1: mem_rd_addr = IDX_W'(i_ff + IDX_W'(1));
         lps_pkg::S_INT_RD0: mem_rd_addr = int_idx;
         lps_pkg::S_END_CHK: begin
            case (step_ff)
               STEP_W'(0): begin mul_a = MOP_W'(gx); mul_b = MOP_W'(gx); end
               STEP_W'(1): begin mul_a = MOP_W'(gy); mul_b = MOP_W'(gy); end
               default: begin
                  mul_a = MOP_W'($signed({1'b0, radius_ff}));
                  mul_b = mul_a;
               end
            endcase
         end
         lps_pkg::S_DIST: begin
            case (step_ff)
               STEP_W'(0): begin mul_a = MOP_W'(qx); mul_b = MOP_W'(qx); end
               STEP_W'(1): begin mul_a = MOP_W'(qy); mul_b = MOP_W'(qy); end
               default: begin
                  mul_a = MOP_W'($signed({1'b0, radius_ff}));
                  mul_b = mul_a;
               end
            endcase
         end
         lps_pkg::S_SEG_MUL: begin
            case (step_ff)
               STEP_W'(0): begin mul_a = MOP_W'(dx); mul_b = MOP_W'(dx); end
               STEP_W'(1): begin mul_a = MOP_W'(dy); mul_b = MOP_W'(dy); end
               STEP_W'(2): begin mul_a = MOP_W'(fx); mul_b = MOP_W'(dx); end
               STEP_W'(3): begin mul_a = MOP_W'(fy); mul_b = MOP_W'(dy); end
               STEP_W'(4): begin mul_a = MOP_W'(fx); mul_b = MOP_W'(fx); end
               STEP_W'(5): begin mul_a = MOP_W'(fy); mul_b = MOP_W'(fy); end
               default: begin
                  mul_a = MOP_W'($signed({1'b0, radius_ff}));
                  mul_b = mul_a;
               end
            endcase
         end
         lps_pkg::S_DISC: begin
            mul_a = $signed({1'b0, half_sel(big_x, step_ff[1])});
            mul_b = $signed({1'b0, half_sel(big_y, step_ff[0])});
         end
         lps_pkg::S_INTERP: begin
            mul_a = (step_ff == '0) ? MOP_W'(dx) : MOP_W'(dy);
            mul_b = MOP_W'($signed({1'b0, sfrac_ff}));
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      step_in   = (state_in != state_ff) ? '0 : step_ff + STEP_W'(1);
      count_in  = count_ff;
      sidx_in   = sidx_ff;
      sfrac_in  = sfrac_ff;
      i_in      = i_ff;
      found_in  = found_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      ex_in     = ex_ff;
      ey_in     = ey_ff;
      fnd_x_in  = fnd_x_ff;
      fnd_y_in  = fnd_y_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      status_in = status_ff;
      prod_in   = PROD_W'(mul_a) * PROD_W'(mul_b);
      a_in      = a_ff;
      h_in      = h_ff;
      c_in      = c_ff;
      acc_in    = acc_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      drem_in   = drem_ff;
      quo_in    = quo_ff;
      isect_in  = isect_ff;
      case (state_ff)
         lps_pkg::S_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  lps_pkg::OP_CLEAR: begin
                     count_in = '0;
                     sidx_in  = '0;
                     sfrac_in = '0;
                  end
                  lps_pkg::OP_APPEND: begin
                     if (mem_wr_en) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  lps_pkg::OP_QUERY: begin
                     px_in     = $signed(req_tdata[CW-1:0]);
                     py_in     = $signed(req_tdata[2*CW-1:CW]);
                     tx_in     = '0;
                     ty_in     = '0;
                     status_in = lps_pkg::STATUS_SHORT;
                  end
                  default: ;
               endcase
            end
         end
         lps_pkg::S_END_CAP, lps_pkg::S_SEG_CAP1, lps_pkg::S_INT_CAP1: begin
            ex_in = rd_x;
            ey_in = rd_y;
         end
         lps_pkg::S_END_CHK: begin
            case (step_ff)
               STEP_W'(1): a_in = prod_ff[SQ_W-1:0];
               STEP_W'(2): a_in = a_ff + prod_ff[SQ_W-1:0];
               STEP_W'(3): begin
                  tx_in     = ex_ff;
                  ty_in     = ey_ff;
                  status_in = lps_pkg::STATUS_END;
               end
               default: ;
            endcase
         end
         lps_pkg::S_SEG_RD0: begin
            i_in     = sidx_ff;
            found_in = '0;
         end
         lps_pkg::S_SEG_CAP0, lps_pkg::S_INT_CAP0: begin
            sx_in = rd_x;
            sy_in = rd_y;
         end
         lps_pkg::S_SEG_MUL: begin
            case (step_ff)
               STEP_W'(1): a_in = prod_ff[SQ_W-1:0];
               STEP_W'(2): a_in = a_ff + prod_ff[SQ_W-1:0];
               STEP_W'(3): h_in = $signed(prod_ff[WIDE_W-1:0]);
               STEP_W'(4): h_in = h_ff + $signed(prod_ff[WIDE_W-1:0]);
               STEP_W'(5): c_in = $signed(prod_ff[WIDE_W-1:0]);
               STEP_W'(6): c_in = c_ff + $signed(prod_ff[WIDE_W-1:0]);
               STEP_W'(7): c_in = c_ff - $signed(prod_ff[WIDE_W-1:0]);
               default: ;
            endcase
         end
         lps_pkg::S_DISC: begin
            // h^2 partials add; a*|c| partials add when c is negative, else subtract
            isect_in = 1'b0;
            if (step_ff == '0) begin
               acc_in = '0;
            end else if ((step_ff >= STEP_W'(5)) && !c_neg) begin
               acc_in = acc_ff - acc_term;
            end else begin
               acc_in = acc_ff + acc_term;
            end
         end
         lps_pkg::S_SQRT_INIT: begin
            rad_in  = acc_ff[RAD_W-1:0];
            root_in = '0;
            srem_in = '0;
         end
         lps_pkg::S_SQRT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            srem_in = sq_ge ? rem_sh - trial : rem_sh;
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
         end
         lps_pkg::S_ROOT: begin
            drem_in = ok1 ? DREM_W'(n1[SQ_W-1:0]) : DREM_W'(n2[SQ_W-1:0]);
            quo_in  = '0;
         end
         lps_pkg::S_DIV: begin
            drem_in = d_ge ? dcand - {1'b0, a_ff} : dcand;
            quo_in  = {quo_ff[FRAC_W-2:0], d_ge};
            if (step_ff == STEP_W'(FRAC_W - 1)) begin
               isect_in = 1'b1;
            end
         end
         lps_pkg::S_CHK: begin
            if (upd) begin
               sidx_in  = i_ff;
               sfrac_in = quo_ff;
            end
            found_in = found_new;
            if (upd && (found_ff == '0)) begin
               fnd_x_in = sx_ff;
               fnd_y_in = sy_ff;
            end
         end
         lps_pkg::S_DIST: begin
            case (step_ff)
               STEP_W'(1): a_in = prod_ff[SQ_W-1:0];
               STEP_W'(2): a_in = a_ff + prod_ff[SQ_W-1:0];
               default: ;
            endcase
         end
         lps_pkg::S_ADV: begin
            i_in  = IDX_W'(i_ff + IDX_W'(1));
            sx_in = ex_ff;
            sy_in = ey_ff;
         end
         lps_pkg::S_INT_RD0: i_in = int_idx;
         lps_pkg::S_INTERP: begin
            // Round to nearest, ties up, then wrap to the coordinate width
            case (step_ff)
               STEP_W'(1): tx_in = sx_ff + $signed(rounded[CW+15:16]);
               STEP_W'(2): begin
                  ty_in     = sy_ff + $signed(rounded[CW+15:16]);
                  status_in = lps_pkg::STATUS_SEGMENT;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (resp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {ty_ff, tx_ff};
         rsp_user_in  = status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lps_pkg::S_IDLE;
         step_ff      <= '0;
         radius_ff    <= '0;
         count_ff     <= '0;
         sidx_ff      <= '0;
         sfrac_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         sidx_ff      <= sidx_in;
         sfrac_ff     <= sfrac_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      found_ff    <= found_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      fnd_x_ff    <= fnd_x_in;
      fnd_y_ff    <= fnd_y_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      status_ff   <= status_in;
      prod_ff     <= prod_in;
      a_ff        <= a_in;
      h_ff        <= h_in;
      c_ff        <= c_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      drem_ff     <= drem_in;
      quo_ff      <= quo_in;
      isect_ff    <= isect_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

// ----- hdl/lps_checker.sv -----
// Port-level checks for lookahead_point_search, attached by bind.
// Depends on lps_pkg.
module lps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result dropped or changed while stalled");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A short path answers with a zero target
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == lps_pkg::STATUS_SHORT) |-> rsp_tdata == '0)
      else $error("short-path result carries a target");

   // A non-query transaction never creates a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != lps_pkg::OP_QUERY) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result without a query");

endmodule

bind lookahead_point_search lps_checker u_lps_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for lookahead_point_search: a point store plus circle-segment search.
// Drives random and directed path and query transactions, predicts every result internally.
// Depends on lps_pkg and the lookahead_point_search RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 256;
   localparam int STALL_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam longint COORD_MIN = -524288;
   localparam longint COORD_MAX = 524287;
   localparam logic [lps_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [lps_pkg::OP_W-1:0]    op;
      logic [lps_pkg::COORD_W-1:0] x;
      logic [lps_pkg::COORD_W-1:0] y;
   } path_item_type;

   typedef struct {
      logic [lps_pkg::COORD_W-1:0]  tx;
      logic [lps_pkg::COORD_W-1:0]  ty;
      logic [lps_pkg::STATUS_W-1:0] status;
   } target_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   path_item_type pending_items[$];
   target_type    expected_targets[$];
   int         mismatches = 0;
   int         req_gap = 0;
   int         rsp_gap = 0;
   bit         steady = 0;
   bit         req_done = 0;
   bit         rsp_done = 0;

   // predictor state
   longint     store_x[STORE_DEPTH];
   longint     store_y[STORE_DEPTH];
   int         stored_points = 0;
   int         track_index = 0;
   longint     track_fraction = 0;
   longint     radius_mm = 0;

   lookahead_point_search u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly back-to-back, sometimes short gaps, rarely long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (steady || roll < 65) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // Far root preferred; returns the Q1.16 crossing fraction on segment k
   function automatic bit segment_crossing(int k, longint px, longint py, output longint frac);
      longint dx, dy, fx, fy, a, h, c, n;
      logic signed [127:0] hw, aw, cw, disc, root, cand;
      dx = store_x[k+1] - store_x[k];
      dy = store_y[k+1] - store_y[k];
      fx = store_x[k] - px;
      fy = store_y[k] - py;
      a = dx * dx + dy * dy;
      h = fx * dx + fy * dy;
      c = fx * fx + fy * fy - radius_mm * radius_mm;
      frac = 0;
      if (a == 0) return 0;
      hw = h;
      aw = a;
      cw = c;
      disc = hw * hw - aw * cw;
      if (disc < 0) return 0;
      root = 0;
      for (int b = 43; b >= 0; b--) begin
         cand = root | (128'sd1 <<< b);
         if (cand * cand <= disc) root = cand;
      end
      n = longint'(root) - h;
      if (n < 0 || n > a) begin
         n = -h - longint'(root);
         if (n < 0 || n > a) return 0;
      end
      frac = (n <<< 16) / a;
      return 1;
   endfunction

   function automatic longint span_sq(int i, int j);
      longint dx, dy;
      dx = store_x[i] - store_x[j];
      dy = store_y[i] - store_y[j];
      return dx * dx + dy * dy;
   endfunction

   // Update the path state for one transaction; return 1 with the target for a query
   function automatic bit lookahead_target(path_item_type it, output target_type res);
      longint px, py, ex, ey, frac, tx, ty;
      int found, idx;
      px = longint'(signed'(it.x));
      py = longint'(signed'(it.y));
      res = '{tx: '0, ty: '0, status: lps_pkg::STATUS_SHORT};
      if (it.op == lps_pkg::OP_CLEAR) begin
         stored_points = 0;
         track_index = 0;
         track_fraction = 0;
         return 0;
      end
      if (it.op == lps_pkg::OP_APPEND) begin
         if (stored_points < STORE_DEPTH) begin
            store_x[stored_points] = px;
            store_y[stored_points] = py;
            stored_points++;
         end
         return 0;
      end
      if (it.op != lps_pkg::OP_QUERY) return 0;
      if (stored_points < 2) return 1;
      ex = store_x[stored_points-1] - px;
      ey = store_y[stored_points-1] - py;
      if (ex * ex + ey * ey <= radius_mm * radius_mm) begin
         res.tx = store_x[stored_points-1][19:0];
         res.ty = store_y[stored_points-1][19:0];
         res.status = lps_pkg::STATUS_END;
         return 1;
      end
      found = 0;
      for (int i = track_index; i + 1 < stored_points; i++) begin
         if (segment_crossing(i, px, py, frac) && (i > track_index || frac > track_fraction))
         begin
            track_index = i;
            track_fraction = frac;
            if (found > 0) break;
            found = i;
         end
         if (found > 0 && span_sq(i, found) >= 4 * radius_mm * radius_mm) break;
      end
      idx = track_index;
      if (idx + 1 >= stored_points) idx = stored_points - 2;
      tx = store_x[idx] + (((store_x[idx+1] - store_x[idx]) * track_fraction + 32768) >>> 16);
      ty = store_y[idx] + (((store_y[idx+1] - store_y[idx]) * track_fraction + 32768) >>> 16);
      res.tx = tx[19:0];
      res.ty = ty[19:0];
      res.status = lps_pkg::STATUS_SEGMENT;
      return 1;
   endfunction

   // Record the handshakes of the last rising edge for the falling-edge drivers
   always @(posedge clock) begin
      req_done = req_tvalid && req_tready;
      rsp_done = rsp_tvalid && rsp_tready;
   end

   // Driver: present queued transactions with random gaps
   always @(negedge clock) begin
      path_item_type it;
      logic nxt_valid;
      nxt_valid = req_tvalid;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_tvalid || req_done) begin
         nxt_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            nxt_valid = 1'b1;
            req_tdata <= {it.y, it.x};
            req_tuser <= it.op;
            req_gap = pick_gap();
         end
      end
      req_tvalid <= nxt_valid;
   end

   // Result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_done) rsp_gap = pick_gap();
      end
   end

   // Monitor: predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      path_item_type it;
      target_type res, want;
      if (!reset && req_tvalid && req_tready) begin
         it = '{op: req_tuser, x: req_tdata[19:0], y: req_tdata[39:20]};
         if (lookahead_target(it, res)) expected_targets.push_back(res);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_targets.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h status=%0d", $time,
                     rsp_tdata[19:0], rsp_tdata[39:20], rsp_tuser);
            mismatches++;
         end else begin
            want = expected_targets.pop_front();
            if (rsp_tdata[19:0] !== want.tx || rsp_tdata[39:20] !== want.ty ||
                rsp_tuser !== want.status) begin
               $display("%0t: expected x=%h y=%h status=%0d, got x=%h y=%h status=%0d",
                        $time, want.tx, want.ty, want.status,
                        rsp_tdata[19:0], rsp_tdata[39:20], rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [19:0] clip(longint v);
      if (v < COORD_MIN) v = COORD_MIN;
      if (v > COORD_MAX) v = COORD_MAX;
      return v[19:0];
   endfunction

   task automatic send(logic [1:0] op, longint x, longint y);
      pending_items.push_back('{op: op, x: clip(x), y: clip(y)});
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_tvalid || expected_targets.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_radius(longint r);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= r[15:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      radius_mm = r;
   endtask

   initial begin
      int sent, npts, nq, pick;
      longint r, x0, y0, step, cx, cy;
      longint px[$], py[$];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // short paths, end within radius zero, extremes, ignored op
      send(lps_pkg::OP_QUERY, 0, 0);
      send(lps_pkg::OP_APPEND, COORD_MIN, COORD_MAX);
      send(lps_pkg::OP_QUERY, 5, 5);
      send(lps_pkg::OP_APPEND, COORD_MAX, COORD_MIN);
      send(lps_pkg::OP_QUERY, COORD_MAX, COORD_MIN);
      send(OP_UNUSED, COORD_MAX, COORD_MAX);
      send(lps_pkg::OP_QUERY, 0, 0);
      set_radius(1000);
      send(lps_pkg::OP_CLEAR, 0, 0);
      send(lps_pkg::OP_APPEND, 0, 0);
      send(lps_pkg::OP_APPEND, 0, 0);
      send(lps_pkg::OP_APPEND, 2000, 0);
      send(lps_pkg::OP_APPEND, 4000, 0);
      send(lps_pkg::OP_APPEND, 4000, 3000);
      send(lps_pkg::OP_QUERY, 0, 0);
      send(lps_pkg::OP_QUERY, 1500, 100);
      send(lps_pkg::OP_QUERY, 500, 0);
      send(lps_pkg::OP_QUERY, 4000, 2500);
      set_radius(65535);
      send(lps_pkg::OP_QUERY, COORD_MIN, COORD_MIN);
      send(lps_pkg::OP_CLEAR, 0, 0);
      send(lps_pkg::OP_APPEND, COORD_MIN, COORD_MIN);
      send(lps_pkg::OP_APPEND, COORD_MAX, COORD_MAX);
      send(lps_pkg::OP_QUERY, 0, -1);
      send(lps_pkg::OP_QUERY, COORD_MIN, COORD_MAX);
      sent = 23;

      // random paths with queries around them
      while (sent < 140) begin
         pick = $urandom_range(9);
         r = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(5000, 1);
         steady = ($urandom_range(3) == 0);
         set_radius(r);
         send(lps_pkg::OP_CLEAR, 0, 0);
         sent++;
         npts = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(12, 2);
         step = 2 * r + 200;
         x0 = longint'($urandom_range(800000)) - 400000;
         y0 = longint'($urandom_range(800000)) - 400000;
         px.delete();
         py.delete();
         for (int k = 0; k < npts; k++) begin
            if ($urandom_range(15) == 0) begin
               cx = longint'($urandom_range(1048575)) - 524288;
               cy = longint'($urandom_range(1048575)) - 524288;
            end else begin
               cx = x0 + longint'($urandom_range(2 * step)) - step;
               cy = y0 + longint'($urandom_range(2 * step)) - step;
               if ($urandom_range(9) == 0) begin
                  cx = x0;
                  cy = y0;
               end
            end
            send(lps_pkg::OP_APPEND, cx, cy);
            px.push_back(clip(cx));
            py.push_back(clip(cy));
            x0 = cx;
            y0 = cy;
            sent++;
         end
         nq = $urandom_range(6, 1);
         for (int q = 0; q < nq; q++) begin
            pick = (npts > 0) ? $urandom_range(npts - 1) : 0;
            cx = (npts > 0) ? longint'(signed'(px[pick][19:0])) : 0;
            cy = (npts > 0) ? longint'(signed'(py[pick][19:0])) : 0;
            if ($urandom_range(4) == 0) begin
               send(OP_UNUSED, cx, cy);
               sent++;
            end
            send(lps_pkg::OP_QUERY, cx + longint'($urandom_range(2 * r + 2)) - r - 1,
                 cy + longint'($urandom_range(2 * r + 2)) - r - 1);
            sent++;
         end
      end

      steady = 0;
      drain();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/lps_pkg.sv
hdl/lps_ram.sv
hdl/lookahead_point_search.sv
hdl/lps_checker.sv
tb/tb.sv
